[rtl/radial_blob_alpha_shader_unit_macros.svh]
// Assertion macros shared by the radial blob alpha shader RTL.
`ifndef RADIAL_BLOB_ALPHA_SHADER_UNIT_MACROS_SVH
`define RADIAL_BLOB_ALPHA_SHADER_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk and disabled during reset.
`define RBAS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbas: same-cycle check failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define RBAS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rbas: next-cycle check failed");
`else
`define RBAS_ASSERT_IMP(label, ante, cons)
`define RBAS_ASSERT_NXT(label, ante, cons)
`endif
`endif

[rtl/rbas_pkg.sv]
// Types, constants and table builders for the radial blob alpha shader.
package rbas_pkg;

	localparam int LOG_TABLE_BITS_DEF = 10;
	// Width of a -log2 result in Q.16 (integer part up to 16).
	localparam int NL_W = 21;
	// Width of a table entry (values up to 1.0 in Q.16).
	localparam int LUT_W = 17;
	localparam logic [LUT_W-1:0] ONE_Q16 = 17'h10000;
	localparam logic [15:0] ALPHA_MAX = 16'hFFFF;

	typedef struct packed {
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic [15:0] out_red;
		logic [15:0] out_green;
		logic [15:0] out_blue;
		logic [15:0] out_alpha;
	} rgba_t;

	typedef enum logic [2:0] {
		CFG_CENTRE_X     = 3'd0,
		CFG_CENTRE_Y     = 3'd1,
		CFG_RADIUS       = 3'd2,
		CFG_SHAPE_EXP    = 3'd3,
		CFG_COLOUR_RED   = 3'd4,
		CFG_COLOUR_GREEN = 3'd5,
		CFG_COLOUR_BLUE  = 3'd6
	} cfg_idx_t;

	// How the final alpha of a request is decided.
	typedef enum logic [1:0] {
		ACODE_CALC = 2'd0,
		ACODE_ZERO = 2'd1,
		ACODE_FULL = 2'd2
	} acode_t;

	// Control that travels with each pipeline slot.
	typedef struct packed {
		logic   valid;
		acode_t code;
	} ctl_t;

	// Integer square root of a 64-bit value, used only to build tables.
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] cand;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if (cand * cand <= v)
				root = cand;
		end
		return root;
	endfunction

	// log2(1 + i / 2^tb) in Q.16, by repeated squaring.
	function automatic logic [LUT_W-1:0] logt_entry(input int tb, input int i);
		logic [63:0] y;
		logic [63:0] acc;
		y = (64'd1 << 30) + (64'(i) << (30 - tb));
		acc = '0;
		for (int k = 0; k < 17; k++) begin
			y = (y * y) >> 30;
			acc = acc << 1;
			if (y >= (64'd1 << 31)) begin
				acc = acc | 64'd1;
				y = y >> 1;
			end
		end
		return LUT_W'((acc + 64'd1) >> 1);
	endfunction

	// 2^(-i / 2^tb) in Q.16, from a chain of square roots of one half.
	function automatic logic [LUT_W-1:0] expt_entry(input int tb, input int i);
		logic [63:0] c [0:15];
		logic [63:0] acc;
		c[0] = 64'd1 << 30;
		for (int k = 1; k <= 15; k++) begin
			if (k <= tb)
				c[k] = isqrt64(c[k-1] << 31);
			else
				c[k] = '0;
		end
		acc = 64'd1 << 31;
		for (int b = 0; b < 15; b++) begin
			if (b < tb && ((i >> b) & 1) != 0)
				acc = (acc * c[tb-b] + (64'd1 << 30)) >> 31;
		end
		return LUT_W'((acc + (64'd1 << 14)) >> 15);
	endfunction

endpackage

[rtl/rbas_log2_neg.sv]
// Three-stage -log2 unit: leading-one normalize, table read, integer merge.
module rbas_log2_neg
	import rbas_pkg::*;
#(
	parameter int TB = LOG_TABLE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  ctl_t            in_ctl,
	input  logic [16:0]     in_val,
	output ctl_t            out_ctl,
	output logic [NL_W-1:0] out_val
);

	localparam int DEPTH = 1 << TB;

	// Constant log table, read through a register.
	logic [LUT_W-1:0] lut [DEPTH];
	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_lut
		localparam logic [LUT_W-1:0] ENTRY = logt_entry(TB, gi);
		assign lut[gi] = ENTRY;
	end

	logic [3:0]       lead;
	logic [15:0]      norm;
	ctl_t             ctl_s1, ctl_s2;
	logic [4:0]       ipart_s1, ipart_s2;
	logic [TB-1:0]    idx_s1;
	logic             big_s1, big_s2;
	logic [LUT_W-1:0] lut_s2;

	// Find the leading one and shift it to the top of the mantissa.
	always_comb begin
		lead = '0;
		for (int b = 0; b < 16; b++) begin
			if (in_val[b])
				lead = 4'(b);
		end
		norm = in_val[15:0] << (4'd15 - lead);
	end

	// Valid and code move with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			out_ctl <= '0;
		end else if (en) begin
			ctl_s1  <= in_ctl;
			ctl_s2  <= ctl_s1;
			out_ctl <= ctl_s2;
		end
	end

	// Values of one and above give zero; otherwise integer part minus table fraction.
	always_ff @(posedge clk) begin
		if (en) begin
			ipart_s1 <= 5'd16 - 5'(lead);
			idx_s1   <= norm[14 -: TB];
			big_s1   <= in_val[16];
			ipart_s2 <= ipart_s1;
			big_s2   <= big_s1;
			lut_s2   <= lut[idx_s1];
			if (big_s2)
				out_val <= '0;
			else
				out_val <= {ipart_s2, 16'h0000} - NL_W'(lut_s2);
		end
	end

endmodule

[rtl/rbas_exp2_neg.sv]
// Three-stage 2^-q unit: split, table read, shift by the integer part.
module rbas_exp2_neg
	import rbas_pkg::*;
#(
	parameter int TB  = LOG_TABLE_BITS_DEF,
	parameter int Q_W = NL_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  ctl_t             in_ctl,
	input  logic [Q_W-1:0]   in_val,
	output ctl_t             out_ctl,
	output logic [LUT_W-1:0] out_val
);

	localparam int DEPTH = 1 << TB;

	// Constant exp table, read through a register.
	logic [LUT_W-1:0] lut [DEPTH];
	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_lut
		localparam logic [LUT_W-1:0] ENTRY = expt_entry(TB, gi);
		assign lut[gi] = ENTRY;
	end

	ctl_t             ctl_s1, ctl_s2;
	logic             big_s1, big_s2;
	logic [4:0]       shift_s1, shift_s2;
	logic [TB-1:0]    idx_s1;
	logic [LUT_W-1:0] lut_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			out_ctl <= '0;
		end else if (en) begin
			ctl_s1  <= in_ctl;
			ctl_s2  <= ctl_s1;
			out_ctl <= ctl_s2;
		end
	end

	// An integer part above sixteen underflows to zero.
	always_ff @(posedge clk) begin
		if (en) begin
			big_s1   <= (in_val[Q_W-1:16] > (Q_W-16)'(16));
			shift_s1 <= in_val[20:16];
			idx_s1   <= in_val[15 -: TB];
			big_s2   <= big_s1;
			shift_s2 <= shift_s1;
			lut_s2   <= lut[idx_s1];
			if (big_s2)
				out_val <= '0;
			else
				out_val <= lut_s2 >> shift_s2;
		end
	end

endmodule

[rtl/radial_blob_alpha_shader_unit.sv]
// Top level of the radial blob alpha shader: config, datapath pipeline, output buffer.
//
// Usage: each pixel request (pixel_x, pixel_y, signed Q1.15) on the pix channel gives one
// rgba result: the configured colour and a coverage alpha (Q0.16) that falls off from
// the blob centre as (1 - d^rho)^(1/rho), zero at and beyond the radius.
// Both channels use valid/stall; a transfer happens when valid is high and stall low.
// Configuration writes use cfg_valid/cfg_ready with cfg_index 0..6 in the order
// centre_x, centre_y, radius, shape exponent, red, green, blue; cfg_ready is always high.
// Write registers only while no requests are in flight.
// Throughput: one request per clock while pix_stall is low. The pipeline has 76 register
// stages: the offset, square and sum stages, the pipelined square root (17 stages),
// the two restoring dividers (16 and 21 stages, one quotient bit each), the four log/exp
// table units (3 stages each), the single-stage steps between them and the output
// register.
// Reset clears all valid bits and loads the register reset values.
// When the receiver stalls, the result holds in the output register, one more result
// goes to a skid register, and then pix_stall rises and the whole pipeline holds.
`include "radial_blob_alpha_shader_unit_macros.svh"
module radial_blob_alpha_shader_unit
	import rbas_pkg::*;
#(
	parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  pixel_t      pix,
	output logic        rgba_valid,
	input  logic        rgba_stall,
	output rgba_t       rgba
);

	localparam int SQ_STEPS = 17;
	localparam int DV1_STEPS = 16;
	localparam int DV2_STEPS = 21;
	localparam int NP_W = 22;
	localparam int NUM_W = 35;

	// Configuration registers.
	logic signed [15:0] centre_x_q, centre_y_q;
	logic [15:0]        radius_q;
	logic [14:0]        rho_q;
	logic [15:0]        red_q, green_q, blue_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q <= '0;
			centre_y_q <= '0;
			radius_q   <= 16'd32768;
			rho_q      <= 15'd15565;
			red_q      <= '0;
			green_q    <= '0;
			blue_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CENTRE_X:     centre_x_q <= cfg_data;
				CFG_CENTRE_Y:     centre_y_q <= cfg_data;
				CFG_RADIUS:       radius_q   <= cfg_data;
				CFG_SHAPE_EXP:    rho_q      <= cfg_data[14:0];
				CFG_COLOUR_RED:   red_q      <= cfg_data;
				CFG_COLOUR_GREEN: green_q    <= cfg_data;
				CFG_COLOUR_BLUE:  blue_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline advances unless the skid register is occupied.
	logic en;
	logic skid_v_q;
	assign en = !skid_v_q;
	assign pix_stall = skid_v_q;

	// Stages 1 to 3: offsets, squares, sum of squares.
	logic               v_s1, v_s2, v_s3;
	logic signed [16:0] dx_s1, dy_s1;
	logic signed [33:0] prod_x, prod_y;
	logic [32:0]        sqx_s2, sqy_s2, sum_s3;

	assign prod_x = dx_s1 * dx_s1;
	assign prod_y = dy_s1 * dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= {centre_x_q[15], centre_x_q} - {pix.pixel_x[15], pix.pixel_x};
			dy_s1  <= {centre_y_q[15], centre_y_q} - {pix.pixel_y[15], pix.pixel_y};
			sqx_s2 <= prod_x[32:0];
			sqy_s2 <= prod_y[32:0];
			sum_s3 <= sqx_s2 + sqy_s2;
		end
	end

	// Square root, one result bit per stage, remainder kept as value minus root squared.
	logic [33:0] sq_rem_s  [1:SQ_STEPS];
	logic [16:0] sq_root_s [1:SQ_STEPS];
	logic        sq_v_s    [1:SQ_STEPS];

	for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
		localparam int B = SQ_STEPS - k;
		logic [33:0] rem_in;
		logic [16:0] root_in;
		logic        v_in;
		logic [33:0] trial;
		if (k == 1) begin : g_first
			assign rem_in  = {1'b0, sum_s3};
			assign root_in = '0;
			assign v_in    = v_s3;
		end else begin : g_next
			assign rem_in  = sq_rem_s[k-1];
			assign root_in = sq_root_s[k-1];
			assign v_in    = sq_v_s[k-1];
		end
		assign trial = (34'(root_in) << (B + 1)) + (34'd1 << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v_s[k] <= 1'b0;
			else if (en)
				sq_v_s[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					sq_rem_s[k]  <= rem_in - trial;
					sq_root_s[k] <= root_in | (17'd1 << B);
				end else begin
					sq_rem_s[k]  <= rem_in;
					sq_root_s[k] <= root_in;
				end
			end
		end
	end

	// Stage 21: outside test and divider seed.
	logic [16:0] dist_root;
	ctl_t        ctl_s21;
	logic [15:0] rem_s21;
	acode_t      code_outside;

	assign dist_root = sq_root_s[SQ_STEPS];
	assign code_outside = (radius_q == '0 || {dist_root, 1'b0} >= 18'(radius_q)) ?
		ACODE_ZERO : ACODE_CALC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s21 <= '0;
		else if (en)
			ctl_s21 <= '{valid: sq_v_s[SQ_STEPS], code: code_outside};
	end

	always_ff @(posedge clk) begin
		if (en)
			rem_s21 <= {dist_root[14:0], 1'b0};
	end

	// Division dist * 2^17 / radius, one quotient bit per stage.
	logic [15:0] dv1_rem_s  [1:DV1_STEPS];
	logic [15:0] dv1_quot_s [1:DV1_STEPS];
	ctl_t        dv1_ctl_s  [1:DV1_STEPS];

	for (genvar k = 1; k <= DV1_STEPS; k++) begin : g_div1
		localparam int QB = DV1_STEPS - k;
		logic [15:0] rem_in;
		logic [15:0] quot_in;
		ctl_t        ctl_in;
		logic [16:0] shifted;
		if (k == 1) begin : g_first
			assign rem_in  = rem_s21;
			assign quot_in = '0;
			assign ctl_in  = ctl_s21;
		end else begin : g_next
			assign rem_in  = dv1_rem_s[k-1];
			assign quot_in = dv1_quot_s[k-1];
			assign ctl_in  = dv1_ctl_s[k-1];
		end
		assign shifted = {rem_in, 1'b0};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv1_ctl_s[k] <= '0;
			else if (en)
				dv1_ctl_s[k] <= ctl_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (shifted >= {1'b0, radius_q}) begin
					dv1_rem_s[k]  <= 16'(shifted - {1'b0, radius_q});
					dv1_quot_s[k] <= quot_in | (16'd1 << QB);
				end else begin
					dv1_rem_s[k]  <= rem_in[15:0] << 1;
					dv1_quot_s[k] <= quot_in;
				end
			end
		end
	end

	// A zero distance quotient, as for a pixel at the centre, gives full coverage.
	logic [15:0] dq;
	ctl_t        lg1_in_ctl;
	ctl_t        lg1_ctl;
	logic [NL_W-1:0] lg1_val;

	assign dq = dv1_quot_s[DV1_STEPS];
	always_comb begin
		lg1_in_ctl = dv1_ctl_s[DV1_STEPS];
		if (lg1_in_ctl.code == ACODE_CALC && dq == '0)
			lg1_in_ctl.code = ACODE_FULL;
	end

	rbas_log2_neg #(
		.TB (LOG_TABLE_BITS)
	) u_log_d (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_ctl  (lg1_in_ctl),
		.in_val  ({1'b0, dq}),
		.out_ctl (lg1_ctl),
		.out_val (lg1_val)
	);

	// Stages 41 and 42: scale the log by rho and round.
	ctl_t            ctl_s41, ctl_s42;
	logic [35:0]     mul_s41;
	logic [NP_W-1:0] np_s42;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s41 <= '0;
			ctl_s42 <= '0;
		end else if (en) begin
			ctl_s41 <= lg1_ctl;
			ctl_s42 <= ctl_s41;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mul_s41 <= 36'(lg1_val) * 36'(rho_q);
			np_s42  <= NP_W'((mul_s41 + 36'h2000) >> 14);
		end
	end

	ctl_t             ex1_ctl;
	logic [LUT_W-1:0] ex1_val;

	rbas_exp2_neg #(
		.TB  (LOG_TABLE_BITS),
		.Q_W (NP_W)
	) u_exp_pow (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_ctl  (ctl_s42),
		.in_val  (np_s42),
		.out_ctl (ex1_ctl),
		.out_val (ex1_val)
	);

	// Stage 46: u = 1 - d^rho; zero u or zero rho gives zero alpha.
	ctl_t             ctl_s46, ctl_u;
	logic [LUT_W-1:0] u_s46;

	always_comb begin
		ctl_u = ex1_ctl;
		if (ex1_ctl.code == ACODE_CALC && (ex1_val == ONE_Q16 || rho_q == '0))
			ctl_u.code = ACODE_ZERO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s46 <= '0;
		else if (en)
			ctl_s46 <= ctl_u;
	end

	always_ff @(posedge clk) begin
		if (en)
			u_s46 <= ONE_Q16 - ex1_val;
	end

	ctl_t            lg2_ctl;
	logic [NL_W-1:0] lg2_val;

	rbas_log2_neg #(
		.TB (LOG_TABLE_BITS)
	) u_log_u (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_ctl  (ctl_s46),
		.in_val  (u_s46),
		.out_ctl (lg2_ctl),
		.out_val (lg2_val)
	);

	// Stage 50: dividend for the rounded division by rho.
	ctl_t             ctl_s50;
	logic [NUM_W-1:0] num_s50;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s50 <= '0;
		else if (en)
			ctl_s50 <= lg2_ctl;
	end

	always_ff @(posedge clk) begin
		if (en)
			num_s50 <= {lg2_val, 14'h0000} + NUM_W'(rho_q >> 1);
	end

	// Stage 51: a quotient of 2^21 or more makes a computed alpha zero.
	ctl_t        ctl_s51, ctl_ovf;
	logic [14:0] rem_s51;
	logic [20:0] lo_s51;

	always_comb begin
		ctl_ovf = ctl_s50;
		if (ctl_s50.code == ACODE_CALC && {1'b0, num_s50[NUM_W-1:21]} >= rho_q)
			ctl_ovf.code = ACODE_ZERO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s51 <= '0;
		else if (en)
			ctl_s51 <= ctl_ovf;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s51 <= {1'b0, num_s50[NUM_W-1:21]};
			lo_s51  <= num_s50[20:0];
		end
	end

	// Division by rho, one quotient bit per stage.
	logic [14:0] dv2_rem_s  [1:DV2_STEPS];
	logic [20:0] dv2_quot_s [1:DV2_STEPS];
	logic [20:0] dv2_lo_s   [1:DV2_STEPS];
	ctl_t        dv2_ctl_s  [1:DV2_STEPS];

	for (genvar k = 1; k <= DV2_STEPS; k++) begin : g_div2
		localparam int QB = DV2_STEPS - k;
		logic [14:0] rem_in;
		logic [20:0] quot_in;
		logic [20:0] lo_in;
		ctl_t        ctl_in;
		logic [15:0] shifted;
		if (k == 1) begin : g_first
			assign rem_in  = rem_s51;
			assign quot_in = '0;
			assign lo_in   = lo_s51;
			assign ctl_in  = ctl_s51;
		end else begin : g_next
			assign rem_in  = dv2_rem_s[k-1];
			assign quot_in = dv2_quot_s[k-1];
			assign lo_in   = dv2_lo_s[k-1];
			assign ctl_in  = dv2_ctl_s[k-1];
		end
		assign shifted = {rem_in, lo_in[QB]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv2_ctl_s[k] <= '0;
			else if (en)
				dv2_ctl_s[k] <= ctl_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv2_lo_s[k] <= lo_in;
				if (shifted >= {1'b0, rho_q}) begin
					dv2_rem_s[k]  <= 15'(shifted - {1'b0, rho_q});
					dv2_quot_s[k] <= quot_in | (21'd1 << QB);
				end else begin
					dv2_rem_s[k]  <= shifted[14:0];
					dv2_quot_s[k] <= quot_in;
				end
			end
		end
	end

	ctl_t             ex2_ctl;
	logic [LUT_W-1:0] ex2_val;

	rbas_exp2_neg #(
		.TB  (LOG_TABLE_BITS),
		.Q_W (NL_W)
	) u_exp_root (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_ctl  (dv2_ctl_s[DV2_STEPS]),
		.in_val  (dv2_quot_s[DV2_STEPS]),
		.out_ctl (ex2_ctl),
		.out_val (ex2_val)
	);

	// Final alpha with saturation, and the result word.
	logic [15:0] alpha;
	rgba_t       res;
	logic        leave;

	always_comb begin
		unique case (ex2_ctl.code)
			ACODE_ZERO: alpha = '0;
			ACODE_FULL: alpha = ALPHA_MAX;
			ACODE_CALC: alpha = ex2_val[16] ? ALPHA_MAX : ex2_val[15:0];
			default:    alpha = '0;
		endcase
		res = '{out_red: red_q, out_green: green_q, out_blue: blue_q, out_alpha: alpha};
	end

	assign leave = ex2_ctl.valid && en;

	// Output register with a skid register behind it.
	rgba_t out_d_q, skid_d_q;
	logic  out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || !rgba_stall) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= leave;
			end
		end else if (leave) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !rgba_stall) begin
			if (skid_v_q)
				out_d_q <= skid_d_q;
			else if (leave)
				out_d_q <= res;
		end else if (leave) begin
			skid_d_q <= res;
		end
	end

	assign rgba_valid = out_v_q;
	assign rgba = out_d_q;

	`RBAS_ASSERT_IMP(a_skid_behind_out, skid_v_q, rgba_valid)
	`RBAS_ASSERT_NXT(a_skid_fills, rgba_valid && rgba_stall && ex2_ctl.valid && !skid_v_q, skid_v_q)
	`RBAS_ASSERT_NXT(a_skid_drains, rgba_valid && !rgba_stall && skid_v_q, rgba_valid && !skid_v_q)

endmodule

[test/tb_top.sv]
// Self-checking testbench for the radial blob alpha shader unit.
`timescale 1ns / 1ps
module tb_top;
	import rbas_pkg::*;

	localparam int TBITS = 10;
	localparam int TSIZE = 1 << TBITS;
	localparam int DRAIN_CYCLES = 100;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        pix_valid;
	logic        pix_stall;
	pixel_t      pix;
	logic        rgba_valid;
	logic        rgba_stall;
	rgba_t       rgba;

	radial_blob_alpha_shader_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
		.rgba_valid(rgba_valid), .rgba_stall(rgba_stall), .rgba(rgba)
	);

	// Shadow copy of the configuration registers.
	logic signed [15:0] ctr_x, ctr_y;
	logic [15:0] blob_rad, red_c, green_c, blue_c;
	logic [14:0] rho;

	logic [63:0] log_lut [0:TSIZE-1];
	logic [63:0] exp_lut [0:TSIZE-1];

	pixel_t pending_pixels [$];
	rgba_t  expected_rgba [$];
	int     mismatches;
	int     send_idle_pct, recv_idle_pct;
	bit     pressure_req, pressure_done;
	int     hold_left;
	int     quiet_cycles;
	bit     pix_taken;

	// Clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (c * c <= v)
				r = c;
		end
		return r;
	endfunction

	// Log and exp tables from integer squaring and square-root chains.
	task automatic build_luts();
		logic [63:0] chain [0:TBITS];
		logic [63:0] y, bits, acc;
		chain[0] = 64'd1 << 30;
		for (int k = 1; k <= TBITS; k++)
			chain[k] = root64(chain[k-1] << 31);
		for (int i = 0; i < TSIZE; i++) begin
			y = (64'(TSIZE) + 64'(i)) << (30 - TBITS);
			bits = '0;
			for (int k = 0; k < 17; k++) begin
				y = (y * y) >> 30;
				bits = bits << 1;
				if (y >= (64'd1 << 31)) begin
					bits = bits | 64'd1;
					y = y >> 1;
				end
			end
			log_lut[i] = (bits + 64'd1) >> 1;
			acc = 64'd1 << 31;
			for (int b = 0; b < TBITS; b++)
				if ((i >> b) & 1)
					acc = (acc * chain[TBITS-b] + (64'd1 << 30)) >> 31;
			exp_lut[i] = (acc + (64'd1 << 14)) >> 15;
		end
	endtask

	// -log2(v / 2^16) in Q.16 for v in 1..65536.
	function automatic logic [63:0] minus_log2(input logic [63:0] v);
		int p;
		logic [31:0] m;
		logic [31:0] idx;
		if (v >= 64'd65536)
			return 64'd0;
		p = 16;
		while (p > 0 && !v[p])
			p--;
		m = 32'(v) << (15 - p);
		idx = ((m - 32'h8000) >> (15 - TBITS)) & (TSIZE - 1);
		return 64'(16 - p) * 64'd65536 - log_lut[idx];
	endfunction

	// 2^(-q / 2^16) in Q1.16.
	function automatic logic [63:0] pow2_neg(input logic [63:0] q);
		logic [63:0] n;
		n = q >> 16;
		if (n > 16)
			return 64'd0;
		return exp_lut[(q >> (16 - TBITS)) & (TSIZE - 1)] >> n;
	endfunction

	// Coverage alpha of one pixel under the current configuration.
	function automatic logic [15:0] blob_alpha(input logic signed [15:0] px,
			input logic signed [15:0] py);
		longint dx, dy;
		logic [63:0] root_d, dq, np, nq, u, a, r, e;
		dx = longint'(ctr_x) - longint'(px);
		dy = longint'(ctr_y) - longint'(py);
		root_d = root64(64'(dx * dx) + 64'(dy * dy));
		r = 64'(blob_rad);
		e = 64'(rho);
		if (r == 0 || 2 * root_d >= r)
			return 16'd0;
		dq = (root_d << 17) / r;
		if (dq == 0)
			return 16'hFFFF;
		np = (minus_log2(dq) * e + 64'h2000) >> 14;
		u = 64'd65536 - pow2_neg(np);
		if (u == 0 || e == 0)
			return 16'd0;
		nq = ((minus_log2(u) << 14) + (e >> 1)) / e;
		a = pow2_neg(nq);
		return (a > 64'd65535) ? 16'hFFFF : a[15:0];
	endfunction

	task automatic report_mismatch(input string field, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch on %s: got %0d, expected %0d", field, got, want);
		mismatches++;
	endtask

	// Prediction on each accepted request, checking on each accepted result,
	// and tracking of configuration writes.
	always @(posedge clk) begin
		rgba_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_CENTRE_X:     ctr_x <= cfg_data;
					CFG_CENTRE_Y:     ctr_y <= cfg_data;
					CFG_RADIUS:       blob_rad <= cfg_data;
					CFG_SHAPE_EXP:    rho <= cfg_data[14:0];
					CFG_COLOUR_RED:   red_c <= cfg_data;
					CFG_COLOUR_GREEN: green_c <= cfg_data;
					CFG_COLOUR_BLUE:  blue_c <= cfg_data;
					default: ;
				endcase
			end
			if (pix_valid && !pix_stall) begin
				want.out_red = red_c;
				want.out_green = green_c;
				want.out_blue = blue_c;
				want.out_alpha = blob_alpha(pix.pixel_x, pix.pixel_y);
				expected_rgba.push_back(want);
			end
			if (rgba_valid && !rgba_stall) begin
				if (expected_rgba.size() == 0) begin
					report_mismatch("unexpected result alpha", rgba.out_alpha, 16'd0);
				end else begin
					want = expected_rgba.pop_front();
					if (rgba.out_red !== want.out_red)
						report_mismatch("out_red", rgba.out_red, want.out_red);
					if (rgba.out_green !== want.out_green)
						report_mismatch("out_green", rgba.out_green, want.out_green);
					if (rgba.out_blue !== want.out_blue)
						report_mismatch("out_blue", rgba.out_blue, want.out_blue);
					if (rgba.out_alpha !== want.out_alpha)
						report_mismatch("out_alpha", rgba.out_alpha, want.out_alpha);
				end
			end
		end
	end

	// Remember whether the request on offer was taken at the last rising edge.
	always @(posedge clk) begin
		pix_taken <= arst_n && pix_valid && !pix_stall;
	end

	// Request driver: a new pixel goes out once the previous one has been taken.
	always @(negedge clk) begin
		if (arst_n && (!pix_valid || pix_taken)) begin
			if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				pix <= pending_pixels.pop_front();
				pix_valid <= 1'b1;
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	// Result receiver with random stalls and one long hold-off on request.
	always @(negedge clk) begin
		if (arst_n) begin
			if (pressure_req && !pressure_done) begin
				pressure_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rgba_stall <= 1'b1;
			end else begin
				rgba_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (pix_valid && !pix_stall) || (rgba_valid && !rgba_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_pixel(input int x, input int y);
		pixel_t p;
		if (x > 32767) x = 32767;
		if (x < -32768) x = -32768;
		if (y > 32767) y = 32767;
		if (y < -32768) y = -32768;
		p.pixel_x = 16'(x);
		p.pixel_y = 16'(y);
		pending_pixels.push_back(p);
	endtask

	// Mostly pixels inside or near the blob, the rest anywhere on the plane.
	task automatic add_random_pixels(input int count);
		int span;
		span = blob_rad / 2 + 2;
		repeat (count) begin
			if ($urandom_range(9) < 7)
				add_pixel(int'(ctr_x) + $urandom_range(2 * span) - span,
					int'(ctr_y) + $urandom_range(2 * span) - span);
			else
				add_pixel($signed(16'($urandom)), $signed(16'($urandom)));
		end
	endtask

	task automatic wait_idle();
		while (pending_pixels.size() != 0 || pix_valid || expected_rgba.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(input logic [15:0] cx, input logic [15:0] cy,
			input logic [15:0] rad, input logic [15:0] shp, input logic [15:0] r,
			input logic [15:0] g, input logic [15:0] b);
		write_reg(CFG_CENTRE_X, cx);
		write_reg(CFG_CENTRE_Y, cy);
		write_reg(CFG_RADIUS, rad);
		write_reg(CFG_SHAPE_EXP, shp);
		write_reg(CFG_COLOUR_RED, r);
		write_reg(CFG_COLOUR_GREEN, g);
		write_reg(CFG_COLOUR_BLUE, b);
		@(posedge clk);
	endtask

	// Stimulus sequence.
	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix_valid = 1'b0;
		pix = '0;
		rgba_stall = 1'b0;
		mismatches = 0;
		pressure_req = 1'b0;
		pressure_done = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		ctr_x = 16'sd0;
		ctr_y = 16'sd0;
		blob_rad = 16'd32768;
		rho = 15'd15565;
		red_c = '0;
		green_c = '0;
		blue_c = '0;
		send_idle_pct = 6;
		recv_idle_pct = 53;
		build_luts();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset configuration: centre, edge of the blob, plane corners.
		add_pixel(0, 0);
		add_pixel(1, 0);
		add_pixel(16383, 0);
		add_pixel(16384, 0);
		add_pixel(0, -16383);
		add_pixel(8192, 8192);
		add_pixel(-32768, -32768);
		add_pixel(32767, 32767);
		add_pixel(-32768, 32767);
		add_random_pixels(150);
		pressure_req = 1'b1;
		wait_idle();

		// Centre in a corner, widest radius, smallest usual rho.
		load_config(16'h8000, 16'h7FFF, 16'hFFFF, 16'd4915, 16'hFFFF, 16'h0000, 16'd12345);
		add_pixel(-32768, 32767);
		add_pixel(32767, -32768);
		add_pixel(0, 0);
		add_random_pixels(200);
		wait_idle();

		// Tiny radius, largest usual rho.
		send_idle_pct = 53;
		recv_idle_pct = 6;
		load_config(16'h7FFF, 16'h8000, 16'd1, 16'd26214, 16'h0000, 16'hFFFF, 16'hA5A5);
		add_pixel(32767, -32768);
		add_pixel(32766, -32768);
		add_random_pixels(150);
		wait_idle();

		// Zero rho, then the largest 15-bit rho.
		load_config(16'd0, 16'd0, 16'd20000, 16'd0, 16'h1234, 16'h5678, 16'h9ABC);
		add_pixel(0, 0);
		add_pixel(100, 100);
		add_random_pixels(100);
		wait_idle();
		write_reg(CFG_SHAPE_EXP, 16'h7FFF);
		@(posedge clk);
		add_pixel(0, 0);
		add_pixel(5000, -3000);
		add_random_pixels(100);
		wait_idle();

		// Zero radius.
		write_reg(CFG_RADIUS, 16'd0);
		@(posedge clk);
		add_pixel(0, 0);
		add_pixel(-1, 1);
		add_random_pixels(10);
		wait_idle();

		// Random settings, no idling.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int k = 0; k < 2; k++) begin
			load_config(16'($urandom), 16'($urandom), 16'($urandom_range(65535, 1)),
				16'($urandom_range(26214, 4915)), 16'($urandom), 16'($urandom),
				16'($urandom));
			add_pixel(ctr_x, ctr_y);
			add_random_pixels(250);
			wait_idle();
		end

		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/rbas_pkg.sv
rtl/rbas_log2_neg.sv
rtl/rbas_exp2_neg.sv
rtl/radial_blob_alpha_shader_unit.sv
test/tb_top.sv
